/* sv/fcp_pkg.sv */
// Shared types and constants of the test command frame parser.
package fcp_pkg;

    // One result record.
    typedef struct packed {
        logic [2:0]  rec_kind;
        logic        section_kind;
        logic [2:0]  op_slot;
        logic [2:0]  action_code;
        logic [2:0]  param_slot;
        logic [31:0] number_value;
        logic [55:0] text_chars;
        logic [2:0]  text_length;
        logic [2:0]  frame_status;
        logic        last_record;
    } t_rec;

    // Records caused by one input beat, at most three.
    typedef struct packed {
        t_rec [2:0] rec;
        logic [1:0] n;
    } t_batch;

    localparam int NUM_ACTIONS = 5;

    // Action names, first character in the low byte.
    localparam logic [55:0] ACT_WORD [NUM_ACTIONS] = '{
        56'h4D5750,    // PWM
        56'h4F495047,  // GPIO
        56'h54524155,  // UART
        56'h495053,    // SPI
        56'h434441     // ADC
    };
    localparam logic [3:0] ACT_LEN [NUM_ACTIONS] = '{4'd3, 4'd4, 4'd4, 4'd3, 4'd3};

    // Section keywords, last character in the low byte.
    localparam logic [63:0] KW_SET     = 64'("SET:");
    localparam logic [63:0] KW_ASSERT  = 64'("ASSERT:");
    localparam logic [63:0] KW_TIMEOUT = 64'("TIMEOUT:");

endpackage

/* sv/fcp_core.sv */
// Parser state register and the single-pass next-state and record logic.
module fcp_core #(
    parameter int MAX_OPERATIONS   = 8,
    parameter int PIN_CHARS        = 7,
    parameter int TEXT_PARAM_CHARS = 7,
    parameter int MAX_PARAMS       = 8,
    parameter int FRAME_LEN        = 255
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_char,
    input  logic           i_eof,
    output fcp_pkg::t_batch o_batch
);
    import fcp_pkg::*;

    localparam int OPW = $clog2(MAX_OPERATIONS + 1);
    localparam int PW  = $clog2(MAX_PARAMS + 1);

    localparam logic [2:0] REC_HDR = 3'd0, REC_NUM = 3'd1, REC_TEXT = 3'd2,
                           REC_TMO = 3'd3, REC_DONE = 3'd4;
    localparam logic [2:0] ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_BAD_ACTION = 3'd2,
                           ST_BAD_FRAME = 3'd3, ST_OPS = 3'd4, ST_PARAMS = 3'd5;
    localparam logic [1:0] SEC_NONE = 2'd0, SEC_SET = 2'd1, SEC_ASSERT = 2'd2,
                           SEC_TIMEOUT = 2'd3;
    localparam logic [7:0] CH_BAR = 8'h7C, CH_COMMA = 8'h2C, CH_COLON = 8'h3A,
                           CH_CR = 8'h0D, CH_LF = 8'h0A, CH_0 = 8'h30, CH_9 = 8'h39,
                           CH_S = 8'h53, CH_A = 8'h41, CH_T = 8'h54, CH_NUL = 8'h00;

    typedef enum logic [6:0] {
        PH_KEY     = 7'b0000001,
        PH_OPGAP   = 7'b0000010,
        PH_ACTION  = 7'b0000100,
        PH_PIN     = 7'b0001000,
        PH_PARAM   = 7'b0010000,
        PH_TIMEOUT = 7'b0100000,
        PH_DONE    = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0]    char_count;
        logic [7:0]    held_char;
        logic          held_valid;
        t_phase        phase;
        logic [3:0]    kw_prog;
        logic [1:0]    section;
        logic [55:0]   tok;
        logic [3:0]    tlen;
        logic [31:0]   acc;
        logic          swd;
        logic          drun;
        logic [2:0]    action;
        logic [OPW-1:0] opc;
        logic [PW-1:0]  npc;
        logic [PW-1:0]  tpc;
        logic [2:0]    status;
    } t_st;

    t_st r_st, n_st;

    function automatic t_st st_reset();
        t_st s;
        s = '0;
        s.phase = PH_KEY;
        return s;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic [31:0] acc_digit(input logic [31:0] a, input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_0;
        return (a << 3) + (a << 1) + {24'd0, d};
    endfunction

    function automatic void emit(input t_st s, inout t_batch o, input logic [2:0] kind,
                                 input logic [2:0] ps, input logic [31:0] num,
                                 input logic [55:0] txt, input logic [2:0] tl,
                                 input logic [2:0] stv);
        t_rec r;
        logic ops;
        ops = (kind <= REC_TEXT);
        r.rec_kind     = kind;
        r.section_kind = ops && (s.section == SEC_ASSERT);
        r.op_slot      = ops ? 3'(s.opc) : 3'd0;
        r.action_code  = ops ? s.action : 3'd0;
        r.param_slot   = ps;
        r.number_value = num;
        r.text_chars   = txt;
        r.text_length  = tl;
        r.frame_status = stv;
        r.last_record  = (kind == REC_DONE);
        if (o.n < 2'd3) begin
            o.rec[o.n] = r;
            o.n = o.n + 2'd1;
        end
    endfunction

    function automatic void fail(inout t_st s, input logic [2:0] code);
        if (s.status == ST_OK) s.status = code;
        s.phase = PH_DONE;
        s.held_valid = 1'b0;
    endfunction

    function automatic void clear_token(inout t_st s);
        s.tok  = '0;
        s.tlen = '0;
        s.swd  = 1'b0;
        s.drun = 1'b0;
        s.acc  = '0;
    endfunction

    function automatic void append(inout t_st s, input logic [7:0] c);
        logic dig;
        dig = is_digit(c);
        if (s.tlen == 4'd0) begin
            s.swd  = dig;
            s.drun = dig;
            s.acc  = '0;
        end
        if (s.tlen < 4'd7) s.tok[s.tlen[2:0]*8 +: 8] = c;
        if (s.tlen < 4'd15) s.tlen = s.tlen + 4'd1;
        if (s.drun) begin
            if (dig) s.acc = acc_digit(s.acc, c);
            else s.drun = 1'b0;
        end
    endfunction

    function automatic void emit_text(input t_st s, inout t_batch o, input logic [2:0] kind,
                                      input logic [2:0] ps, input logic [3:0] keep);
        logic [3:0]  n;
        logic [55:0] txt;
        n = (s.tlen < keep) ? s.tlen : keep;
        txt = '0;
        for (int i = 0; i < 7; i++) begin
            if (4'(i) < n) txt[i*8 +: 8] = s.tok[i*8 +: 8];
        end
        emit(s, o, kind, ps, 32'd0, txt, n[2:0], ST_OK);
    endfunction

    function automatic logic take_action(inout t_st s);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_ACTIONS; i++) begin
            if (!hit && s.tlen == ACT_LEN[i] && s.tok == ACT_WORD[i]) begin
                s.action = 3'(i);
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void emit_param(inout t_st s, inout t_batch o);
        if (s.swd) begin
            if (s.npc >= PW'(MAX_PARAMS)) begin
                fail(s, ST_PARAMS);
            end else begin
                emit(s, o, REC_NUM, 3'(s.npc), s.acc, 56'd0, 3'd0, ST_OK);
                s.npc = s.npc + 1'b1;
            end
        end else begin
            if (s.tpc >= PW'(MAX_PARAMS)) begin
                fail(s, ST_PARAMS);
            end else begin
                emit_text(s, o, REC_TEXT, 3'(s.tpc), 4'(TEXT_PARAM_CHARS));
                s.tpc = s.tpc + 1'b1;
            end
        end
    endfunction

    // ':' closed a non-empty field
    function automatic void field_end(inout t_st s, inout t_batch o);
        if (s.phase == PH_ACTION) begin
            if (!take_action(s)) begin
                fail(s, ST_BAD_ACTION);
                return;
            end
            s.phase = PH_PIN;
        end else if (s.phase == PH_PIN) begin
            emit_text(s, o, REC_HDR, 3'd0, 4'(PIN_CHARS));
            s.phase = PH_PARAM;
        end else begin
            emit_param(s, o);
            if (s.phase == PH_DONE) return;
        end
        clear_token(s);
    endfunction

    function automatic void finish_op(inout t_st s, inout t_batch o);
        if (s.phase == PH_ACTION) begin
            if (s.tlen != 4'd0 && !take_action(s)) fail(s, ST_BAD_ACTION);
            else fail(s, ST_BAD_FRAME);
            return;
        end
        if (s.phase == PH_PIN) begin
            if (s.tlen == 4'd0) begin
                fail(s, ST_BAD_FRAME);
                return;
            end
            emit_text(s, o, REC_HDR, 3'd0, 4'(PIN_CHARS));
        end else if (s.tlen != 4'd0) begin
            emit_param(s, o);
            if (s.phase == PH_DONE) return;
        end
        s.opc = s.opc + 1'b1;
        clear_token(s);
        s.phase = PH_OPGAP;
    endfunction

    function automatic void start_keyword(inout t_st s);
        s.phase   = PH_KEY;
        s.kw_prog = '0;
        s.section = SEC_NONE;
    endfunction

    function automatic void keyword_char(inout t_st s, input logic [7:0] c);
        logic [63:0] kw;
        logic [3:0]  len;
        logic [2:0]  pos;
        if (c == CH_BAR) begin
            if (s.kw_prog != 4'd0) fail(s, ST_BAD_FRAME);
            return;
        end
        if (s.kw_prog == 4'd0) begin
            if (c == CH_S) s.section = SEC_SET;
            else if (c == CH_A) s.section = SEC_ASSERT;
            else if (c == CH_T) s.section = SEC_TIMEOUT;
            else begin
                fail(s, ST_BAD_FRAME);
                return;
            end
        end
        kw  = (s.section == SEC_SET) ? KW_SET :
              (s.section == SEC_ASSERT) ? KW_ASSERT : KW_TIMEOUT;
        len = (s.section == SEC_SET) ? 4'd4 : (s.section == SEC_ASSERT) ? 4'd7 : 4'd8;
        if (s.kw_prog >= len) begin
            fail(s, ST_BAD_FRAME);
            return;
        end
        pos = 3'(len - 4'd1 - s.kw_prog);
        if (kw[pos*8 +: 8] != c) begin
            fail(s, ST_BAD_FRAME);
            return;
        end
        s.kw_prog = s.kw_prog + 4'd1;
        if (s.kw_prog == len) begin
            clear_token(s);
            if (s.section == SEC_TIMEOUT) begin
                s.drun  = 1'b1;
                s.phase = PH_TIMEOUT;
            end else begin
                s.opc   = '0;
                s.phase = PH_OPGAP;
            end
        end
    endfunction

    function automatic void process(inout t_st s, inout t_batch o, input logic [7:0] c);
        case (s.phase)
            PH_KEY: begin
                keyword_char(s, c);
            end
            PH_OPGAP: begin
                if (c == CH_BAR) begin
                    start_keyword(s);
                end else if (c != CH_COMMA) begin
                    if (s.opc >= OPW'(MAX_OPERATIONS)) begin
                        fail(s, ST_OPS);
                    end else begin
                        s.npc = '0;
                        s.tpc = '0;
                        clear_token(s);
                        s.phase = PH_ACTION;
                        if (c != CH_COLON) append(s, c);
                    end
                end
            end
            PH_ACTION, PH_PIN, PH_PARAM: begin
                if (c == CH_BAR) begin
                    finish_op(s, o);
                    if (s.phase != PH_DONE) start_keyword(s);
                end else if (c == CH_COMMA) begin
                    finish_op(s, o);
                end else if (c == CH_COLON) begin
                    if (s.tlen != 4'd0) field_end(s, o);
                end else begin
                    append(s, c);
                end
            end
            PH_TIMEOUT: begin
                if (c == CH_BAR) begin
                    emit(s, o, REC_TMO, 3'd0, s.acc, 56'd0, 3'd0, ST_OK);
                    start_keyword(s);
                end else if (s.drun) begin
                    if (is_digit(c)) s.acc = acc_digit(s.acc, c);
                    else s.drun = 1'b0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void end_text(inout t_st s, inout t_batch o);
        if (s.held_valid) begin
            s.held_valid = 1'b0;
            if (s.held_char != CH_CR && s.held_char != CH_LF) process(s, o, s.held_char);
        end
        if (s.phase == PH_KEY) begin
            if (s.kw_prog != 4'd0) fail(s, ST_BAD_FRAME);
        end else if (s.phase == PH_ACTION || s.phase == PH_PIN || s.phase == PH_PARAM) begin
            finish_op(s, o);
        end else if (s.phase == PH_TIMEOUT) begin
            emit(s, o, REC_TMO, 3'd0, s.acc, 56'd0, 3'd0, ST_OK);
        end
        if (s.char_count == 8'd0 && s.status == ST_OK) s.status = ST_EMPTY;
        s.phase = PH_DONE;
    endfunction

    always_comb begin
        n_st    = r_st;
        o_batch = '0;
        if (n_st.phase != PH_DONE) begin
            if (i_char == CH_NUL) begin
                end_text(n_st, o_batch);
            end else if (n_st.char_count < 8'(FRAME_LEN)) begin
                n_st.char_count = n_st.char_count + 8'd1;
                if (n_st.held_valid) process(n_st, o_batch, n_st.held_char);
                if (n_st.phase != PH_DONE) begin
                    n_st.held_char  = i_char;
                    n_st.held_valid = 1'b1;
                end
            end
        end
        if (i_eof) begin
            if (n_st.phase != PH_DONE) end_text(n_st, o_batch);
            emit(n_st, o_batch, REC_DONE, 3'd0, 32'd0, 56'd0, 3'd0, n_st.status);
            n_st = st_reset();
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= st_reset();
        end else if (i_take) begin
            r_st <= n_st;
        end
    end

endmodule

/* sv/fcp_out_buf.sv */
// Result register: holds the records of one beat and hands them out one at a time.
module fcp_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  fcp_pkg::t_batch i_batch,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output fcp_pkg::t_rec   o_rec
);
    import fcp_pkg::*;

    t_rec [2:0] r_rec;
    logic [1:0] r_n;
    logic [1:0] r_idx;
    logic       pop;

    assign o_valid = (r_idx != r_n);
    assign pop     = o_valid && i_ready;
    assign o_free  = !o_valid || (pop && (r_idx + 2'd1 == r_n));
    assign o_rec   = (r_idx == 2'd3) ? '0 : r_rec[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_n   <= i_batch.n;
            r_idx <= 2'd0;
        end else if (pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_batch.rec;
        end
    end

endmodule

/* sv/test_command_frame_parser.sv */
// Top level of the test command frame parser.
//
// Slave stream: one frame character per beat. tdata[7:0] is the character,
// tlast marks the final beat of the frame. A NUL character ends the text;
// beats after it, up to tlast, are dropped.
// Master stream: one record per beat. tuser holds the record kind and the
// section kind, tdata the remaining record fields, tlast the frame done record.
// Each beat can cause up to three records. They are produced in the cycle the
// beat is accepted and appear on the master side from the next cycle, one per
// cycle unless stalled. A new beat is taken whenever the result register is
// empty or drains its last record in the same cycle, so beats causing at most one
// record flow at one per cycle; a beat causing more records holds the slave side
// until its last record is taken. The parser holds each character back one beat
// to drop a trailing CR or LF. Reset (synchronous, active low) returns the parser
// to the keyword phase and empties the result register. A stalled master side
// holds the current record stable and backs up into the slave side through tready.
module test_command_frame_parser #(
    parameter int MAX_OPERATIONS   = 8,
    parameter int PIN_CHARS        = 7,
    parameter int TEXT_PARAM_CHARS = 7,
    parameter int MAX_PARAMS       = 8,
    parameter int FRAME_LEN        = 255
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] char_code
    input  logic         i_s_axis_tlast,   // end_of_frame
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [2:0] op_slot, [5:3] action_code, [8:6] param_slot, [40:9] number_value,
    // [96:41] text_chars, [99:97] text_length, [102:100] frame_status, [103] zero
    output logic [103:0] o_m_axis_tdata,
    output logic [3:0]   o_m_axis_tuser,   // [2:0] rec_kind, [3] section_kind
    output logic         o_m_axis_tlast    // last_record
);
    import fcp_pkg::*;

    logic   take;
    logic   free;
    t_batch batch;
    t_rec   rec;

    assign o_s_axis_tready = free;
    assign take            = i_s_axis_tvalid && free;

    fcp_core #(
        .MAX_OPERATIONS  (MAX_OPERATIONS),
        .PIN_CHARS       (PIN_CHARS),
        .TEXT_PARAM_CHARS(TEXT_PARAM_CHARS),
        .MAX_PARAMS      (MAX_PARAMS),
        .FRAME_LEN       (FRAME_LEN)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_char (i_s_axis_tdata),
        .i_eof  (i_s_axis_tlast),
        .o_batch(batch)
    );

    fcp_out_buf u_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (take),
        .i_batch(batch),
        .o_free (free),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_rec  (rec)
    );

    assign o_m_axis_tdata = {1'b0, rec.frame_status, rec.text_length, rec.text_chars,
                             rec.number_value, rec.param_slot, rec.action_code, rec.op_slot};
    assign o_m_axis_tuser = {rec.section_kind, rec.rec_kind};
    assign o_m_axis_tlast = rec.last_record;

endmodule

/* sim/frame_checker.sv */
// Checker for the command frame parser: predicts records per input beat and compares them.
`timescale 1ns / 1ps

module frame_checker
    import fcp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_valid,
    input  logic         i_s_ready,
    input  logic [7:0]   i_s_data,
    input  logic         i_s_last,
    input  logic         i_m_valid,
    input  logic         i_m_ready,
    input  logic [103:0] i_m_data,
    input  logic [3:0]   i_m_user,
    input  logic         i_m_last,
    output int           o_errors,
    output int           o_pending
);

    typedef enum logic [2:0] {
        PH_KEY, PH_OPGAP, PH_ACTION, PH_PIN, PH_PARAM, PH_TIMEOUT, PH_DONE
    } t_phase;
    typedef enum logic [1:0] {SEC_NONE, SEC_SET, SEC_ASSERT, SEC_TIMEOUT} t_sect;

    localparam logic [2:0] REC_HDR = 3'd0, REC_NUM = 3'd1, REC_TEXT = 3'd2,
                           REC_TMO = 3'd3, REC_DONE = 3'd4;
    localparam logic [2:0] ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_BAD_ACTION = 3'd2,
                           ST_BAD_FRAME = 3'd3, ST_TOO_MANY_OPS = 3'd4,
                           ST_TOO_MANY_PARAMS = 3'd5;
    localparam int N_OPS = 8, PIN_KEEP = 7, TEXT_KEEP = 7, N_PARAMS = 8, F_LEN = 255;

    t_rec        exp_recs[$];

    // parser mirror
    logic [7:0]  n_chars, held;
    bit          held_v, dig_start, dig_run;
    t_phase      phase;
    logic [3:0]  kw_pos;
    t_sect       sect;
    logic [63:0] tok;
    logic [3:0]  tok_len;
    logic [31:0] acc;
    logic [2:0]  act;
    logic [3:0]  op_cnt, num_cnt, txt_cnt;
    logic [2:0]  status;

    function automatic void put_rec(logic [2:0] kind, logic [3:0] pslot, logic [31:0] num,
                                    logic [63:0] text, logic [3:0] tlen, logic [2:0] st);
        t_rec r;
        bit   ops;
        ops = (kind <= REC_TEXT);
        r.rec_kind     = kind;
        r.section_kind = ops && (sect == SEC_ASSERT);
        r.op_slot      = ops ? op_cnt[2:0] : 3'd0;
        r.action_code  = ops ? act : 3'd0;
        r.param_slot   = pslot[2:0];
        r.number_value = num;
        r.text_chars   = text[55:0];
        r.text_length  = tlen[2:0];
        r.frame_status = st;
        r.last_record  = (kind == REC_DONE);
        exp_recs.push_back(r);
    endfunction

    function automatic void fail(logic [2:0] code);
        if (status == ST_OK) status = code;
        phase  = PH_DONE;
        held_v = 0;
    endfunction

    function automatic void clear_tok();
        tok = '0; tok_len = '0; dig_start = 0; dig_run = 0; acc = '0;
    endfunction

    function automatic void reset_state();
        n_chars = '0; held = '0; held_v = 0; phase = PH_KEY; kw_pos = '0;
        sect = SEC_NONE; clear_tok(); act = '0; op_cnt = '0; num_cnt = '0;
        txt_cnt = '0; status = ST_OK;
    endfunction

    function automatic void append(logic [7:0] c);
        bit dig;
        dig = (c >= "0" && c <= "9");
        if (tok_len == 0) begin
            dig_start = dig; dig_run = dig; acc = '0;
        end
        if (tok_len < 8) tok |= 64'(c) << (8 * tok_len);
        if (tok_len < 15) tok_len++;
        if (dig_run) begin
            if (dig) acc = acc * 10 + 32'(c - "0");
            else dig_run = 0;
        end
    endfunction

    function automatic void emit_text(logic [2:0] kind, logic [3:0] pslot, int keep);
        int          n;
        logic [63:0] mask;
        n    = (tok_len < keep) ? tok_len : keep;
        mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 1);
        put_rec(kind, pslot, '0, tok & mask, 4'(n), ST_OK);
    endfunction

    function automatic bit take_action();
        for (int i = 0; i < NUM_ACTIONS; i++) begin
            if (tok_len == ACT_LEN[i] && tok == {8'h00, ACT_WORD[i]}) begin
                act = 3'(i);
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void emit_param();
        if (dig_start) begin
            if (num_cnt >= N_PARAMS) begin fail(ST_TOO_MANY_PARAMS); return; end
            put_rec(REC_NUM, num_cnt, acc, '0, '0, ST_OK);
            num_cnt++;
        end else begin
            if (txt_cnt >= N_PARAMS) begin fail(ST_TOO_MANY_PARAMS); return; end
            emit_text(REC_TEXT, txt_cnt, TEXT_KEEP);
            txt_cnt++;
        end
    endfunction

    // ':' closed a non-empty field
    function automatic void field_end();
        if (phase == PH_ACTION) begin
            if (!take_action()) begin fail(ST_BAD_ACTION); return; end
            phase = PH_PIN;
        end else if (phase == PH_PIN) begin
            emit_text(REC_HDR, '0, PIN_KEEP);
            phase = PH_PARAM;
        end else begin
            emit_param();
            if (phase == PH_DONE) return;
        end
        clear_tok();
    endfunction

    function automatic void finish_op();
        if (phase == PH_ACTION) begin
            if (tok_len > 0 && !take_action()) fail(ST_BAD_ACTION);
            else fail(ST_BAD_FRAME);
            return;
        end
        if (phase == PH_PIN) begin
            if (tok_len == 0) begin fail(ST_BAD_FRAME); return; end
            emit_text(REC_HDR, '0, PIN_KEEP);
        end else if (tok_len > 0) begin
            emit_param();
            if (phase == PH_DONE) return;
        end
        op_cnt++;
        clear_tok();
        phase = PH_OPGAP;
    endfunction

    function automatic void start_key();
        phase = PH_KEY; kw_pos = '0; sect = SEC_NONE;
    endfunction

    function automatic void keyword_char(logic [7:0] c);
        string kw;
        if (c == "|") begin
            if (kw_pos != 0) fail(ST_BAD_FRAME);
            return;
        end
        if (kw_pos == 0) begin
            if (c == "S") sect = SEC_SET;
            else if (c == "A") sect = SEC_ASSERT;
            else if (c == "T") sect = SEC_TIMEOUT;
            else begin fail(ST_BAD_FRAME); return; end
        end
        kw = (sect == SEC_SET) ? "SET:" : (sect == SEC_ASSERT) ? "ASSERT:" : "TIMEOUT:";
        if (kw_pos >= kw.len() || kw[kw_pos] != c) begin fail(ST_BAD_FRAME); return; end
        kw_pos++;
        if (kw_pos == kw.len()) begin
            clear_tok();
            if (sect == SEC_TIMEOUT) begin
                dig_run = 1;
                phase   = PH_TIMEOUT;
            end else begin
                op_cnt = '0;
                phase  = PH_OPGAP;
            end
        end
    endfunction

    function automatic void parse_char(logic [7:0] c);
        case (phase)
            PH_KEY: keyword_char(c);
            PH_OPGAP: begin
                if (c == "|") start_key();
                else if (c != ",") begin
                    if (op_cnt >= N_OPS) begin fail(ST_TOO_MANY_OPS); return; end
                    num_cnt = '0; txt_cnt = '0;
                    clear_tok();
                    phase = PH_ACTION;
                    if (c != ":") append(c);
                end
            end
            PH_ACTION, PH_PIN, PH_PARAM: begin
                if (c == "|") begin
                    finish_op();
                    if (phase != PH_DONE) start_key();
                end else if (c == ",") finish_op();
                else if (c == ":") begin
                    if (tok_len > 0) field_end();
                end else append(c);
            end
            PH_TIMEOUT: begin
                if (c == "|") begin
                    put_rec(REC_TMO, '0, acc, '0, '0, ST_OK);
                    start_key();
                end else if (dig_run) begin
                    if (c >= "0" && c <= "9") acc = acc * 10 + 32'(c - "0");
                    else dig_run = 0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void end_text();
        if (held_v) begin
            held_v = 0;
            // a final CR or LF is dropped
            if (held != 8'h0d && held != 8'h0a) parse_char(held);
        end
        if (phase == PH_KEY) begin
            if (kw_pos != 0) fail(ST_BAD_FRAME);
        end else if (phase inside {PH_ACTION, PH_PIN, PH_PARAM}) finish_op();
        else if (phase == PH_TIMEOUT) put_rec(REC_TMO, '0, acc, '0, '0, ST_OK);
        if (n_chars == 0 && status == ST_OK) status = ST_EMPTY;
        phase = PH_DONE;
    endfunction

    function automatic void predict_beat(logic [7:0] c, logic eof);
        if (phase != PH_DONE) begin
            if (c == 8'h00) end_text();
            else if (n_chars < F_LEN) begin
                n_chars++;
                if (held_v) parse_char(held);
                if (phase != PH_DONE) begin
                    held = c; held_v = 1;
                end
            end
        end
        if (eof) begin
            if (phase != PH_DONE) end_text();
            put_rec(REC_DONE, '0, '0, '0, '0, status);
            reset_state();
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_errors++;
        end
    endfunction

    initial begin
        o_errors  = 0;
        o_pending = 0;
        reset_state();
    end

    always @(posedge i_clk) begin
        t_rec r;
        if (!i_rst_n) begin
            reset_state();
            exp_recs.delete();
        end else begin
            // records leave before the beat taken at this edge can add any
            if (i_m_valid && i_m_ready) begin
                if (exp_recs.size() == 0) begin
                    $error("record with nothing expected: tuser %0h tdata %0h",
                           i_m_user, i_m_data);
                    o_errors++;
                end else begin
                    r = exp_recs.pop_front();
                    check_field("rec_kind",     r.rec_kind,     i_m_user[2:0]);
                    check_field("section_kind", r.section_kind, i_m_user[3]);
                    check_field("op_slot",      r.op_slot,      i_m_data[2:0]);
                    check_field("action_code",  r.action_code,  i_m_data[5:3]);
                    check_field("param_slot",   r.param_slot,   i_m_data[8:6]);
                    check_field("number_value", r.number_value, i_m_data[40:9]);
                    check_field("text_chars",   r.text_chars,   i_m_data[96:41]);
                    check_field("text_length",  r.text_length,  i_m_data[99:97]);
                    check_field("frame_status", r.frame_status, i_m_data[102:100]);
                    check_field("tdata pad",    1'b0,           i_m_data[103]);
                    check_field("last_record",  r.last_record,  i_m_last);
                end
            end
            if (i_s_valid && i_s_ready) predict_beat(i_s_data, i_s_last);
        end
        o_pending <= exp_recs.size();
    end

endmodule

/* sim/tb_top.sv */
// Testbench top for the command frame parser: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] char_code
    logic         s_tlast;   // end_of_frame
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;   // op_slot, action_code, param_slot, number, text, len, status
    logic [3:0]   m_tuser;   // [2:0] rec_kind, [3] section_kind
    logic         m_tlast;   // last_record

    int           errors;
    int           pending;
    bit           calm;      // no gaps on either side while set
    logic [7:0]   frame_buf[$];
    int           chars_sent;

    test_command_frame_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    frame_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_s_ready (s_tready),
        .i_s_data  (s_tdata),
        .i_s_last  (s_tlast),
        .i_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .i_m_data  (m_tdata),
        .i_m_user  (m_tuser),
        .i_m_last  (m_tlast),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        if (calm || $urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(15, 40);
        return $urandom_range(1, 3);
    endfunction

    // Receiver stalls.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic add_str(string s);
        foreach (s[i]) frame_buf.push_back(s[i]);
    endtask

    task automatic add_rand_text(int len, bit digits);
        for (int i = 0; i < len; i++)
            frame_buf.push_back(digits ? 8'($urandom_range("0", "9"))
                                       : 8'($urandom_range("A", "Z")));
    endtask

    // Delimiter, doubled now and then (a run counts as one).
    task automatic add_delim(string d);
        add_str(d);
        if ($urandom_range(0, 5) == 0) add_str(d);
    endtask

    task automatic add_op();
        string names[5] = '{"PWM", "GPIO", "UART", "SPI", "ADC"};
        int    np;
        if ($urandom_range(0, 12) == 0) add_str("PWX");
        else add_str(names[$urandom_range(0, 4)]);
        add_delim(":");
        // pin, sometimes missing or longer than kept
        add_rand_text($urandom_range(0, 12) == 0 ? 0 : $urandom_range(1, 9),
                      $urandom_range(0, 3) == 0);
        np = $urandom_range(0, 3);
        for (int p = 0; p < np; p++) begin
            add_delim(":");
            if ($urandom_range(0, 1)) add_rand_text($urandom_range(1, 12), 1);
            else add_rand_text($urandom_range(1, 9), 0);
        end
    endtask

    task automatic build_frame(int kind);
        int nsec, nop;
        frame_buf.delete();
        case (kind)
            0: begin  // more operations than a section holds
                add_str("SET:");
                for (int i = 0; i < 9; i++) add_str("SPI:q,");
            end
            1: begin  // more params of one kind than allowed
                add_str("ASSERT:GPIO:x");
                for (int i = 0; i < 9; i++) add_str(":7");
            end
            2: begin  // timeout wraps
                add_str("TIMEOUT:");
                add_rand_text(14, 1);
            end
            3: begin  // noise, any byte but NUL
                for (int i = $urandom_range(1, 12); i > 0; i--)
                    frame_buf.push_back(8'($urandom_range(1, 255)));
            end
            default: begin
                nsec = $urandom_range(1, 3);
                for (int s = 0; s < nsec; s++) begin
                    if (s > 0) add_delim("|");
                    case ($urandom_range(0, 4))
                        0: begin
                            add_str("TIMEOUT:");
                            if ($urandom_range(0, 5) == 0) add_str($urandom_range(0, 1) ? "-" : " ");
                            add_rand_text($urandom_range(0, 11), 1);
                        end
                        1, 2: add_str("SET:");
                        default: add_str("ASSERT:");
                    endcase
                    if (frame_buf[frame_buf.size() - 1] == ":") begin
                        nop = $urandom_range(1, 3);
                        for (int o = 0; o < nop; o++) begin
                            if (o > 0) add_delim(",");
                            add_op();
                        end
                    end
                end
                // damage one character now and then
                if ($urandom_range(0, 7) == 0)
                    frame_buf[$urandom_range(0, frame_buf.size() - 1)] =
                        8'($urandom_range(1, 255));
                if ($urandom_range(0, 3) == 0) add_str($urandom_range(0, 1) ? "\r" : "\n");
                // early NUL with junk after it
                if ($urandom_range(0, 7) == 0) begin
                    frame_buf.push_back(8'h00);
                    add_rand_text($urandom_range(1, 4), 0);
                end
            end
        endcase
    endtask

    // One beat; valid stays high across back-to-back beats.
    task automatic send_beat(logic [7:0] c, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        chars_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_beat(frame_buf[i], i == frame_buf.size() - 1);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_text(string s, bit nul_end);
        frame_buf.delete();
        add_str(s);
        if (nul_end) frame_buf.push_back(8'h00);
        send_frame();
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int fidx;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        i_rst_n    = 1'b0;
        calm       = 1'b0;
        chars_sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, lone delimiter, trailing newline, bad keyword,
        // keyword cut short by a NUL, wrapping numeric param
        send_text("", 1);
        send_text("|", 0);
        send_text("SET:ADC:p:9\n", 0);
        send_text("XY", 0);
        send_text("T", 1);
        frame_buf.delete();
        add_str("SET:UART:a:4294967296");
        frame_buf.push_back(8'hff);
        send_frame();

        // the sender holds off until every record is out
        wait_drained();

        fidx = 0;
        while (chars_sent < 170 || fidx < 8) begin
            calm = ($urandom_range(0, 5) == 0);
            build_frame(fidx < 4 ? fidx : $urandom_range(3, 12));
            send_frame();
            if (fidx == 5) wait_drained();
            fidx++;
        end
        calm = 1'b0;

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
